// ----- rtl/core/ffa_pkg.sv -----
`timescale 1ns / 1ps

package ffa_pkg;

    localparam int FREE_ENTRIES_DEF = 64;
    localparam int LIVE_ENTRIES_DEF = 64;
    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int ALIGN_BYTES_DEF  = 8;
    localparam int HEADER_BYTES_DEF = 8;

    localparam logic [1:0] CFG_SEGMENT_BYTES   = 2'd0;
    localparam logic [1:0] CFG_MIN_ALLOC_BYTES = 2'd1;
    localparam logic [1:0] CFG_SPLIT_THRESHOLD = 2'd2;

    localparam logic [20:0] SEGMENT_BYTES_RST   = 21'd65536;
    localparam logic [12:0] MIN_ALLOC_BYTES_RST = 13'd16;
    localparam logic [12:0] SPLIT_THRESHOLD_RST = 13'd16;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] KIND_NULL  = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NULL_NOOP  = 3'd1;
    localparam logic [2:0] ST_OUT_OF_MEM = 3'd2;
    localparam logic [2:0] ST_UNKNOWN    = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [21:0] size;
        logic [23:0] key;
    } ffa_item_t;

    typedef struct packed {
        logic [23:0] result_address;
        logic [2:0]  status;
        logic [24:0] total_bytes;
        logic [24:0] unused_bytes;
    } ffa_result_t;

    typedef struct packed {
        logic [20:0] segment_bytes;
        logic [12:0] min_alloc_bytes;
        logic [12:0] split_threshold;
    } ffa_cfg_t;

endpackage

// ----- rtl/core/first_fit_free_list_allocator.sv -----
`timescale 1ns / 1ps

// First-fit allocator over a segmented arena. Requests enter through a queue-style
// port: push with command, request_bytes and body_address, accepted when full is low.
// Each request gives one result, read while empty is low and taken with pop.
// An allocate first has its size raised to min_alloc_bytes and rounded up to the
// alignment in the front stage with a reciprocal multiply. The back stage then finds
// a live slot, one slot per cycle, and scans the free list from its head, rotating
// one entry per cycle, so that a scan and its restore leave the list in its order.
// A free scans the live table one entry per cycle. Results reach the output in the
// cycle after the back stage finishes a request.
// Requests are handled one at a time in the back stage; a two-entry queue between the
// stages and a two-entry result queue let either side stall without losing data.
// When the receiver stops popping, the result queue fills and the back stage holds.
// Reset empties both queues, clears the free list count, the tail, the segment and
// byte counters and all live flags, and loads the register reset values.
// Configuration writes take effect at once and belong only to idle periods.
module first_fit_free_list_allocator
    import ffa_pkg::*;
#(
    parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
    parameter int LIVE_ENTRIES = LIVE_ENTRIES_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        config_write,
    input  logic [1:0]  config_index,
    input  logic [20:0] config_data,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [20:0] request_bytes,
    input  logic [23:0] body_address,
    output logic        empty,
    input  logic        pop,
    output logic [23:0] result_address,
    output logic [2:0]  status,
    output logic [24:0] total_bytes,
    output logic [24:0] unused_bytes
);

    ffa_cfg_t    cfg_reg;
    logic        q_valid, q_ready;
    ffa_item_t   q_item;
    logic        res_wr, res_full;
    ffa_result_t res_data, out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.segment_bytes   <= SEGMENT_BYTES_RST;
            cfg_reg.min_alloc_bytes <= MIN_ALLOC_BYTES_RST;
            cfg_reg.split_threshold <= SPLIT_THRESHOLD_RST;
        end
        else if (config_write)
        begin
            case (config_index)
                CFG_SEGMENT_BYTES:   cfg_reg.segment_bytes   <= config_data;
                CFG_MIN_ALLOC_BYTES: cfg_reg.min_alloc_bytes <= config_data[12:0];
                CFG_SPLIT_THRESHOLD: cfg_reg.split_threshold <= config_data[12:0];
                default:
                begin
                end
            endcase
        end
    end

    ffa_front #(
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .command         (command),
        .request_bytes   (request_bytes),
        .body_address    (body_address),
        .min_alloc_bytes (cfg_reg.min_alloc_bytes),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item)
    );

    ffa_back #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .LIVE_ENTRIES (LIVE_ENTRIES),
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .res_wr   (res_wr),
        .res_data (res_data),
        .res_full (res_full)
    );

    ffa_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_wr),
        .wr_data (res_data),
        .oq_full (res_full),
        .pop     (pop),
        .empty   (empty),
        .rd_data (out_data)
    );

    assign result_address = out_data.result_address;
    assign status         = out_data.status;
    assign total_bytes    = out_data.total_bytes;
    assign unused_bytes   = out_data.unused_bytes;

endmodule

// ----- rtl/core/ffa_front.sv -----
`timescale 1ns / 1ps

module ffa_front
    import ffa_pkg::*;
#(
    parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [20:0] request_bytes,
    input  logic [23:0] body_address,
    input  logic [12:0] min_alloc_bytes,
    output logic        q_valid,
    input  logic        q_ready,
    output ffa_item_t   q_item
);

    localparam int RS = 28;
    localparam logic [28:0] RM = 29'(((64'd1 << RS) + 64'(ALIGN_BYTES) - 64'd1) /
                                     64'(ALIGN_BYTES));

    logic              pend_reg, pend_next;
    logic              div_reg, div_next;
    logic              phase_reg, phase_next;
    logic [21:0]       quo_reg, quo_next;
    ffa_item_t         item_reg, item_next;
    ffa_item_t         fifo_reg [2];
    logic              wptr_reg, rptr_reg;
    logic [1:0]        qcnt_reg;
    logic              enq, deq;
    logic [21:0]       up;
    logic [50:0]       prod;
    logic [20:0]       raised;
    logic              accept;

    assign full    = pend_reg;
    assign accept  = push && !pend_reg;
    assign raised  = ({8'd0, min_alloc_bytes} >= request_bytes) ?
                     {8'd0, min_alloc_bytes} : request_bytes;
    assign up      = item_reg.size + 22'(ALIGN_BYTES - 1);
    assign prod    = 51'(up) * 51'(RM);
    assign enq     = pend_reg && !div_reg && (qcnt_reg != 2'd2);
    assign deq     = q_valid && q_ready;
    assign q_valid = (qcnt_reg != 2'd0);
    assign q_item  = fifo_reg[rptr_reg];

    always_comb
    begin
        pend_next  = pend_reg;
        div_next   = div_reg;
        phase_next = phase_reg;
        quo_next   = quo_reg;
        item_next  = item_reg;
        if (enq)
        begin
            pend_next = 1'b0;
        end
        if (accept)
        begin
            pend_next      = 1'b1;
            item_next.size = 22'd0;
            item_next.key  = body_address - 24'(HEADER_BYTES);
            if (command == CMD_FREE)
            begin
                item_next.kind = (body_address == 24'd0) ? KIND_NULL : KIND_FREE;
            end
            else if (request_bytes == 21'd0)
            begin
                item_next.kind = KIND_NULL;
            end
            else
            begin
                item_next.kind = KIND_ALLOC;
                item_next.size = {1'b0, raised};
                div_next       = 1'b1;
                phase_next     = 1'b0;
            end
        end
        else if (div_reg)
        begin
            if (!phase_reg)
            begin
                quo_next   = prod[RS+21:RS];
                phase_next = 1'b1;
            end
            else
            begin
                item_next.size = 22'(28'(quo_reg) * 28'(ALIGN_BYTES));
                div_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            div_reg  <= 1'b0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            qcnt_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            div_reg  <= div_next;
            if (enq)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (deq)
            begin
                rptr_reg <= !rptr_reg;
            end
            qcnt_reg <= qcnt_reg + {1'b0, enq} - {1'b0, deq};
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        quo_reg   <= quo_next;
        item_reg  <= item_next;
        if (enq)
        begin
            fifo_reg[wptr_reg] <= item_reg;
        end
    end

endmodule

// ----- rtl/core/ffa_outq.sv -----
`timescale 1ns / 1ps

module ffa_outq
    import ffa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr,
    input  ffa_result_t wr_data,
    output logic        oq_full,
    input  logic        pop,
    output logic        empty,
    output ffa_result_t rd_data
);

    ffa_result_t mem_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  cnt_reg;
    logic        do_wr, do_rd;

    assign oq_full = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr && !oq_full;
    assign do_rd   = pop && !empty;
    assign rd_data = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/ffa_back.sv -----
`timescale 1ns / 1ps

module ffa_back
    import ffa_pkg::*;
#(
    parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
    parameter int LIVE_ENTRIES = LIVE_ENTRIES_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ffa_cfg_t    cfg,
    input  logic        q_valid,
    output logic        q_ready,
    input  ffa_item_t   q_item,
    output logic        res_wr,
    output ffa_result_t res_data,
    input  logic        res_full
);

    localparam int FCW = $clog2(FREE_ENTRIES + 1);
    localparam int LIW = $clog2(LIVE_ENTRIES);
    localparam int LCW = $clog2(LIVE_ENTRIES + 1);
    localparam int SCW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [23:0] HDR = 24'(HEADER_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SLOT  = 4'd1;
    localparam logic [3:0] S_LSCAN = 4'd2;
    localparam logic [3:0] S_LROT  = 4'd3;
    localparam logic [3:0] S_SPLIT = 4'd4;
    localparam logic [3:0] S_TAIL  = 4'd5;
    localparam logic [3:0] S_TAIL2 = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_FSCAN = 4'd8;
    localparam logic [3:0] S_FDO   = 4'd9;
    localparam logic [3:0] S_RESP  = 4'd10;

    localparam logic [1:0] FOP_NONE = 2'd0;
    localparam logic [1:0] FOP_PUSH = 2'd1;
    localparam logic [1:0] FOP_POP  = 2'd2;
    localparam logic [1:0] FOP_ROT  = 2'd3;

    logic [3:0]              state_reg, state_next;
    ffa_item_t               item_reg, item_next;
    logic [FCW-1:0]          fcnt_reg, fcnt_next;
    logic [FCW-1:0]          k_reg, k_next;
    logic [LIW-1:0]          slot_reg, slot_next;
    logic [LCW-1:0]          sidx_reg, sidx_next;
    logic                    pv_reg, pv_next;
    logic [LIW-1:0]          jq_reg, jq_next;
    logic [23:0]             cstart_reg, cstart_next;
    logic [23:0]             clen_reg, clen_next;
    logic [23:0]             tstart_reg, tstart_next;
    logic [23:0]             tlen_reg, tlen_next;
    logic                    tvalid_reg, tvalid_next;
    logic [SCW-1:0]          seg_reg, seg_next;
    logic [24:0]             total_reg, total_next;
    logic [24:0]             unused_reg, unused_next;
    logic [2:0]              status_reg, status_next;
    logic [23:0]             result_reg, result_next;
    logic [LIVE_ENTRIES-1:0] lvalid_reg, lvalid_next;

    logic [23:0]             fs_reg [FREE_ENTRIES];
    logic [23:0]             fl_reg [FREE_ENTRIES];
    logic [1:0]              fop;
    logic [23:0]             fp_start, fp_len;

    logic [23:0]             lst_mem [LIVE_ENTRIES];
    logic [23:0]             lln_mem [LIVE_ENTRIES];
    logic [23:0]             rd_start_reg, rd_len_reg;
    logic [LIW-1:0]          rd_addr;
    logic                    live_we;

    logic [23:0]             size24;
    logic [23:0]             l_left, t_left;
    logic                    l_split, t_split;
    logic [25:0]             seg_end;
    logic [24:0]             tot;

    assign size24  = {2'b00, item_reg.size};
    assign l_left  = clen_reg - size24;
    assign l_split = (l_left > {11'd0, cfg.split_threshold}) && (l_left >= HDR);
    assign t_left  = tlen_reg - size24;
    assign t_split = (t_left > {11'd0, cfg.split_threshold}) && (t_left >= HDR);
    assign seg_end = {1'b0, total_reg} + {5'd0, cfg.segment_bytes};
    assign tot     = {1'b0, clen_reg} + {1'b0, HDR};
    assign q_ready = (state_reg == S_IDLE);
    assign res_wr  = (state_reg == S_RESP);
    assign res_data.result_address = result_reg;
    assign res_data.status         = status_reg;
    assign res_data.total_bytes    = total_reg;
    assign res_data.unused_bytes   = unused_reg;
    assign live_we = (state_reg == S_FIN);

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        fcnt_next   = fcnt_reg;
        k_next      = k_reg;
        slot_next   = slot_reg;
        sidx_next   = sidx_reg;
        pv_next     = pv_reg;
        jq_next     = jq_reg;
        cstart_next = cstart_reg;
        clen_next   = clen_reg;
        tstart_next = tstart_reg;
        tlen_next   = tlen_reg;
        tvalid_next = tvalid_reg;
        seg_next    = seg_reg;
        total_next  = total_reg;
        unused_next = unused_reg;
        status_next = status_reg;
        result_next = result_reg;
        lvalid_next = lvalid_reg;
        fop         = FOP_NONE;
        fp_start    = cstart_reg;
        fp_len      = clen_reg;
        rd_addr     = sidx_reg[LIW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_next   = q_item;
                    result_next = 24'd0;
                    status_next = ST_OK;
                    sidx_next   = '0;
                    pv_next     = 1'b0;
                    case (q_item.kind)
                        KIND_ALLOC: state_next = S_SLOT;
                        KIND_FREE:  state_next = S_FSCAN;
                        default:
                        begin
                            status_next = ST_NULL_NOOP;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end
            S_SLOT:
            begin
                if (!lvalid_reg[sidx_reg[LIW-1:0]])
                begin
                    slot_next  = sidx_reg[LIW-1:0];
                    k_next     = '0;
                    state_next = (fcnt_reg == '0) ? S_TAIL : S_LSCAN;
                end
                else if (sidx_reg == LCW'(LIVE_ENTRIES - 1))
                begin
                    status_next = ST_TABLE_FULL;
                    state_next  = S_RESP;
                end
                else
                begin
                    sidx_next = sidx_reg + 1'b1;
                end
            end
            S_LSCAN:
            begin
                if (fl_reg[0] >= size24)
                begin
                    cstart_next = fs_reg[0];
                    clen_next   = fl_reg[0];
                    fop         = FOP_POP;
                    fcnt_next   = fcnt_reg - 1'b1;
                    k_next      = fcnt_reg - k_reg - 1'b1;
                    state_next  = S_LROT;
                end
                else
                begin
                    fop = FOP_ROT;
                    if ((k_reg + 1'b1) == fcnt_reg)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            S_LROT:
            begin
                if (k_reg == '0)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    fop    = FOP_ROT;
                    k_next = k_reg - 1'b1;
                end
            end
            S_SPLIT:
            begin
                if (l_split)
                begin
                    fop       = FOP_PUSH;
                    fp_start  = cstart_reg + HDR + size24;
                    fp_len    = l_left - HDR;
                    fcnt_next = fcnt_reg + 1'b1;
                    clen_next = size24;
                end
                state_next = S_FIN;
            end
            S_TAIL, S_TAIL2:
            begin
                if (tvalid_reg && (tlen_reg >= size24))
                begin
                    cstart_next = tstart_reg;
                    if (t_split)
                    begin
                        clen_next   = size24;
                        tstart_next = tstart_reg + HDR + size24;
                        tlen_next   = t_left - HDR;
                    end
                    else
                    begin
                        clen_next   = tlen_reg;
                        tvalid_next = 1'b0;
                    end
                    state_next = S_FIN;
                end
                else if (state_reg == S_TAIL2)
                begin
                    status_next = ST_OUT_OF_MEM;
                    state_next  = S_RESP;
                end
                else if ((seg_reg >= SCW'(MAX_SEGMENTS)) ||
                         ({3'd0, cfg.segment_bytes} < HDR) ||
                         (seg_end > 26'd16777216))
                begin
                    status_next = ST_OUT_OF_MEM;
                    state_next  = S_RESP;
                end
                else if (tvalid_reg && (fcnt_reg >= FCW'(FREE_ENTRIES)))
                begin
                    status_next = ST_TABLE_FULL;
                    state_next  = S_RESP;
                end
                else
                begin
                    if (tvalid_reg)
                    begin
                        fop       = FOP_PUSH;
                        fp_start  = tstart_reg;
                        fp_len    = tlen_reg;
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                    tstart_next = total_reg[23:0];
                    tlen_next   = {3'd0, cfg.segment_bytes} - HDR;
                    tvalid_next = 1'b1;
                    seg_next    = seg_reg + 1'b1;
                    total_next  = seg_end[24:0];
                    unused_next = unused_reg + {4'd0, cfg.segment_bytes};
                    state_next  = S_TAIL2;
                end
            end
            S_FIN:
            begin
                unused_next = (unused_reg >= tot) ? (unused_reg - tot) : 25'd0;
                lvalid_next[slot_reg] = 1'b1;
                result_next = cstart_reg + HDR;
                state_next  = S_RESP;
            end
            S_FSCAN:
            begin
                if (pv_reg && lvalid_reg[jq_reg] && (rd_start_reg == item_reg.key))
                begin
                    slot_next   = jq_reg;
                    cstart_next = rd_start_reg;
                    clen_next   = rd_len_reg;
                    state_next  = S_FDO;
                end
                else if (sidx_reg == LCW'(LIVE_ENTRIES))
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        status_next = ST_UNKNOWN;
                        state_next  = S_RESP;
                    end
                end
                else
                begin
                    pv_next   = 1'b1;
                    jq_next   = sidx_reg[LIW-1:0];
                    sidx_next = sidx_reg + 1'b1;
                end
            end
            S_FDO:
            begin
                if (fcnt_reg >= FCW'(FREE_ENTRIES))
                begin
                    status_next = ST_TABLE_FULL;
                end
                else
                begin
                    lvalid_next[slot_reg] = 1'b0;
                    fop         = FOP_PUSH;
                    fcnt_next   = fcnt_reg + 1'b1;
                    unused_next = unused_reg + tot;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!res_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fcnt_reg   <= '0;
            pv_reg     <= 1'b0;
            tstart_reg <= 24'd0;
            tlen_reg   <= 24'd0;
            tvalid_reg <= 1'b0;
            seg_reg    <= '0;
            total_reg  <= 25'd0;
            unused_reg <= 25'd0;
            lvalid_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fcnt_reg   <= fcnt_next;
            pv_reg     <= pv_next;
            tstart_reg <= tstart_next;
            tlen_reg   <= tlen_next;
            tvalid_reg <= tvalid_next;
            seg_reg    <= seg_next;
            total_reg  <= total_next;
            unused_reg <= unused_next;
            lvalid_reg <= lvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        k_reg      <= k_next;
        slot_reg   <= slot_next;
        sidx_reg   <= sidx_next;
        jq_reg     <= jq_next;
        cstart_reg <= cstart_next;
        clen_reg   <= clen_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    // The free list is kept in order, head at entry zero; a scan rotates it through the head.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < FREE_ENTRIES; j++)
        begin
            case (fop)
                FOP_PUSH:
                begin
                    if (j == 0)
                    begin
                        fs_reg[j] <= fp_start;
                        fl_reg[j] <= fp_len;
                    end
                    else
                    begin
                        fs_reg[j] <= fs_reg[j-1];
                        fl_reg[j] <= fl_reg[j-1];
                    end
                end
                FOP_POP:
                begin
                    if (j < FREE_ENTRIES - 1)
                    begin
                        fs_reg[j] <= fs_reg[j+1];
                        fl_reg[j] <= fl_reg[j+1];
                    end
                end
                FOP_ROT:
                begin
                    if (FCW'(j) == (fcnt_reg - 1'b1))
                    begin
                        fs_reg[j] <= fs_reg[0];
                        fl_reg[j] <= fl_reg[0];
                    end
                    else if (j < FREE_ENTRIES - 1)
                    begin
                        fs_reg[j] <= fs_reg[j+1];
                        fl_reg[j] <= fl_reg[j+1];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            lst_mem[slot_reg] <= cstart_reg;
            lln_mem[slot_reg] <= clen_reg;
        end
        rd_start_reg <= lst_mem[rd_addr];
        rd_len_reg   <= lln_mem[rd_addr];
    end

    a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FCW'(FREE_ENTRIES))
        else $error("free list count exceeds its capacity");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LSCAN) |-> (fcnt_reg != '0) && (k_reg < fcnt_reg))
        else $error("list scan on an empty list or past its end");

    a_fin_marks_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> lvalid_reg[$past(slot_reg)])
        else $error("granted chunk not marked live");

    a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLIT) |-> (fcnt_reg < FCW'(FREE_ENTRIES)))
        else $error("split remainder pushed onto a full list");

endmodule
